// ----- src/sem_pkg.sv -----
`timescale 1ns / 1ps

package sem_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned ROW_W      = 16;
  localparam int unsigned COL_OUT_W  = 10;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST  = 11'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST = 16'd480;
  localparam logic [PIX_W-1:0] MAG_MAX          = 8'd255;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;   // take the input word, step the counters, read the line stores
    logic fetch;  // shift the window, write the line stores, form gradients
    logic sum;    // square and add, arm the root search
    logic root;   // one bit of the root search
    logic emit;   // load the output word
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic interior;   // current word produces a result
    logic root_last;  // root search is on its last bit
  } status_t;

endpackage

// ----- src/sem_ctrl.sv -----
`timescale 1ns / 1ps

module sem_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  sem_pkg::status_t status_i,
  output sem_pkg::cmd_t    cmd_o
);
  import sem_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_FETCH = 5'b00010,
    S_SUM   = 5'b00100,
    S_ROOT  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d     = status_i.interior ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_ROOT;
      end
      S_ROOT: begin
        cmd_o.root = 1'b1;
        if (status_i.root_last) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // hold until the output register is free or being drained
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// ----- src/sem_datapath.sv -----
`timescale 1ns / 1ps

module sem_datapath #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [sem_pkg::PIX_W-1:0]           pixel_i,
  input  sem_pkg::cmd_t                       cmd_i,
  output sem_pkg::status_t                    status_o,
  output logic [sem_pkg::PIX_W-1:0]           magnitude_o,
  output logic [sem_pkg::ROW_W-1:0]           out_row_o,
  output logic [sem_pkg::COL_OUT_W-1:0]       out_col_o,
  output logic                                frame_done_o
);
  import sem_pkg::*;

  localparam int unsigned CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned WRQ = $clog2(MAX_WIDTH + 1);
  localparam int unsigned WW  = (WRQ > FW_W) ? WRQ : FW_W;
  localparam int unsigned RW  = ROW_W + 1;
  localparam int unsigned GW  = 11;  // signed gradient, |g| <= 1020
  localparam int unsigned SW  = 21;  // sum of squares, < 2**21

  // configuration
  logic [FW_W-1:0] frame_width_q;
  logic [FH_W-1:0] frame_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= FRAME_WIDTH_RST;
      frame_height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[FW_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[FH_W-1:0];
        default: ;
      endcase
    end
  end

  // effective frame size
  logic [WW-1:0] fw_ext, w_eff;
  logic [RW-1:0] h_eff;

  assign fw_ext = WW'(frame_width_q);
  assign w_eff  = (fw_ext < WW'(3)) ? WW'(3) :
                  (fw_ext > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : fw_ext;
  assign h_eff  = (frame_height_q < FH_W'(3)) ? RW'(3) : RW'(frame_height_q);

  // position counters
  logic [CW-1:0]    col_q;
  logic [ROW_W-1:0] row_q;
  logic [WW-1:0]    c_adj, c_next;
  logic [RW-1:0]    r_tmp, r_adj, r_next;
  logic             interior_d;

  always_comb begin
    if (WW'(col_q) >= w_eff) begin
      c_adj = '0;
      r_tmp = RW'(row_q) + RW'(1);
    end else begin
      c_adj = WW'(col_q);
      r_tmp = RW'(row_q);
    end
    r_adj = (r_tmp >= h_eff) ? '0 : r_tmp;

    c_next = c_adj + WW'(1);
    r_next = r_adj;
    if (c_next >= w_eff) begin
      c_next = '0;
      r_next = r_adj + RW'(1);
      if (r_next >= h_eff) begin
        r_next = '0;
      end
    end
    interior_d = (r_adj >= RW'(2)) && (c_adj >= WW'(2));
  end

  logic [CW-1:0]        addr_q;
  logic [PIX_W-1:0]     pix_q;
  logic                 interior_q;
  logic [ROW_W-1:0]     row_item_q;
  logic [COL_OUT_W-1:0] col_item_q;
  logic                 done_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      interior_q <= 1'b0;
    end else if (cmd_i.load) begin
      col_q      <= c_next[CW-1:0];
      row_q      <= r_next[ROW_W-1:0];
      interior_q <= interior_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      addr_q      <= c_adj[CW-1:0];
      pix_q       <= pixel_i;
      row_item_q  <= r_adj[ROW_W-1:0] - ROW_W'(1);
      col_item_q  <= c_adj[COL_OUT_W-1:0] - COL_OUT_W'(1);
      done_item_q <= (r_adj == h_eff - RW'(1)) && (c_adj == w_eff - WW'(1));
    end
  end

  // line stores
  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];
  logic [PIX_W-1:0] up_rd_q, mid_rd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      up_rd_q  <= upper_mem[c_adj[CW-1:0]];
      mid_rd_q <= middle_mem[c_adj[CW-1:0]];
    end
    if (cmd_i.fetch) begin
      upper_mem[addr_q]  <= mid_rd_q;
      middle_mem[addr_q] <= pix_q;
    end
  end

  // 3x3 window: columns hold top, middle, bottom from low byte up
  logic [3*PIX_W-1:0] prev1_q, prev2_q, cur;

  assign cur = {pix_q, mid_rd_q, up_rd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev1_q <= '0;
      prev2_q <= '0;
    end else if (cmd_i.fetch) begin
      prev2_q <= prev1_q;
      prev1_q <= cur;
    end
  end

  // gradients
  logic [GW-1:0]        gx_pos, gx_neg, gy_pos, gy_neg;
  logic signed [GW-1:0] gx_q, gy_q;

  assign gx_pos = GW'(cur[7:0]) + GW'({cur[15:8], 1'b0}) + GW'(cur[23:16]);
  assign gx_neg = GW'(prev2_q[7:0]) + GW'({prev2_q[15:8], 1'b0}) + GW'(prev2_q[23:16]);
  assign gy_pos = GW'(prev2_q[23:16]) + GW'({prev1_q[23:16], 1'b0}) + GW'(cur[23:16]);
  assign gy_neg = GW'(prev2_q[7:0]) + GW'({prev1_q[7:0], 1'b0}) + GW'(cur[7:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fetch) begin
      gx_q <= $signed(gx_pos - gx_neg);
      gy_q <= $signed(gy_pos - gy_neg);
    end
  end

  // sum of squares
  logic signed [2*GW-1:0] sq_x, sq_y;
  logic [SW-1:0]          sum_q;

  assign sq_x = gx_q * gx_q;
  assign sq_y = gy_q * gy_q;

  // root search, one result bit per cycle from the top
  logic [PIX_W-1:0]   root_q, bit_q, trial;
  logic [2*PIX_W-1:0] trial_sq;
  logic               sat;

  assign trial    = root_q | bit_q;
  assign trial_sq = trial * trial;
  assign sat      = |sum_q[SW-1:2*PIX_W];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      sum_q  <= sq_x[SW-1:0] + sq_y[SW-1:0];
      root_q <= '0;
      bit_q  <= {1'b1, {(PIX_W-1){1'b0}}};
    end else if (cmd_i.root) begin
      if (SW'(trial_sq) <= sum_q) begin
        root_q <= trial;
      end
      bit_q <= bit_q >> 1;
    end
  end

  // output word
  logic [PIX_W-1:0]     magnitude_q;
  logic [ROW_W-1:0]     out_row_q;
  logic [COL_OUT_W-1:0] out_col_q;
  logic                 frame_done_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      magnitude_q  <= sat ? MAG_MAX : root_q;
      out_row_q    <= row_item_q;
      out_col_q    <= col_item_q;
      frame_done_q <= done_item_q;
    end
  end

  assign magnitude_o  = magnitude_q;
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign frame_done_o = frame_done_q;

  assign status_o.interior  = interior_q;
  assign status_o.root_last = bit_q[0];

endmodule

// ----- src/sobel_edge_magnitude.sv -----
`timescale 1ns / 1ps

// 3x3 Sobel gradient magnitude over a raster-order stream of 8-bit pixels.
// Input channel: in_valid_i / in_stall_o with pixel_i; one word per pixel.
// Output channel: out_valid_o / out_stall_i with magnitude_o, out_row_o,
// out_col_o and frame_done_o; one word per interior pixel (row and column
// not on the frame border), frame_done_o set on the last one of a frame.
// The word for interior pixel (r-1, c-1) comes from the input word (r, c).
// Frame size is set through cfg_we_i / cfg_index_i / cfg_data_i; write it
// only while no word is in flight.
// Sequencing: every accepted pixel passes load and fetch; a border pixel
// then frees the block, while an interior one goes on through sum, the
// bit-serial square-root search, one result bit per cycle, and emit,
// which loads the output word; no new pixel is accepted before that.
// The output register lets the next pixel be accepted while a result
// waits; a stalled receiver holds the block only when a second result is
// ready behind it.
// Reset restores 640 x 480, zeroes the window and the position counters;
// the line stores are not cleared, they fill during the first two rows.
module sobel_edge_magnitude #(
  parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [sem_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sem_pkg::PIX_W-1:0]      pixel_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sem_pkg::PIX_W-1:0]      magnitude_o,
  output logic [sem_pkg::ROW_W-1:0]      out_row_o,
  output logic [sem_pkg::COL_OUT_W-1:0]  out_col_o,
  output logic                           frame_done_o
);
  import sem_pkg::*;

  cmd_t    cmd;
  status_t status;

  sem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sem_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .pixel_i      (pixel_i),
    .cmd_i        (cmd),
    .status_o     (status),
    .magnitude_o  (magnitude_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_done_o (frame_done_o)
  );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import sem_pkg::*;

  localparam int unsigned LINE_DEPTH = MAX_WIDTH_DEF;
  localparam int unsigned LINE_AW    = $clog2(LINE_DEPTH);
  // leave margin after the last word before touching the registers
  localparam int unsigned QUIET_CYCLES = 20;

  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] middle;
    logic [PIX_W-1:0] bottom;
  } column_t;

  typedef struct packed {
    logic [PIX_W-1:0]     magnitude;
    logic [ROW_W-1:0]     row;
    logic [COL_OUT_W-1:0] col;
    logic                 done;
  } edge_word_t;

  typedef enum int {TEX_NOISE, TEX_BINARY, TEX_SMOOTH} texture_e;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic [PIX_W-1:0]      pixel     = '0;
  logic                  out_stall = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [PIX_W-1:0]      magnitude;
  logic [ROW_W-1:0]      out_row;
  logic [COL_OUT_W-1:0]  out_col;
  logic                  frame_done;

  int unsigned sender_idle_pct = 38;
  int unsigned stall_pct       = 66;
  int unsigned mismatch_count  = 0;

  // shadow of the block: registers, line stores, window and position
  int unsigned      width_reg  = 32'(FRAME_WIDTH_RST);
  int unsigned      height_reg = 32'(FRAME_HEIGHT_RST);
  logic [PIX_W-1:0] upper_line  [LINE_DEPTH];
  logic [PIX_W-1:0] middle_line [LINE_DEPTH];
  column_t          prev1      = '0;
  column_t          prev2      = '0;
  int unsigned      col_pos    = 0;
  int unsigned      row_pos    = 0;
  edge_word_t       pending_edges [$];

  sobel_edge_magnitude i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .pixel_i      (pixel),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .magnitude_o  (magnitude),
    .out_row_o    (out_row),
    .out_col_o    (out_col),
    .frame_done_o (frame_done)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned active_width();
    if (width_reg < 3) return 3;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned active_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  function automatic int column_weight(input column_t col);
    return int'(col.top) + 2 * int'(col.middle) + int'(col.bottom);
  endfunction

  function automatic int unsigned floor_root(input int unsigned energy);
    int unsigned root;
    root = 0;
    if (energy >= 65536) return 32'(MAG_MAX);
    while ((root + 1) * (root + 1) <= energy) root++;
    return root;
  endfunction

  // advance the shadow by one pixel and queue the word it produces, if any
  task automatic predict_pixel(input logic [PIX_W-1:0] value);
    int unsigned        w, h, c, r, energy;
    int                 gx, gy;
    column_t            now;
    edge_word_t         word;
    logic [LINE_AW-1:0] slot;
    w = active_width();
    h = active_height();
    c = col_pos;
    r = row_pos;
    if (c >= w) begin
      c = 0;
      r++;
    end
    if (r >= h) r = 0;
    slot              = c[LINE_AW-1:0];
    now.top           = upper_line[slot];
    now.middle        = middle_line[slot];
    now.bottom        = value;
    upper_line[slot]  = middle_line[slot];
    middle_line[slot] = value;
    if (r >= 2 && c >= 2) begin
      gx = column_weight(now) - column_weight(prev2);
      gy = (int'(prev2.bottom) + 2 * int'(prev1.bottom) + int'(now.bottom))
         - (int'(prev2.top) + 2 * int'(prev1.top) + int'(now.top));
      energy = $unsigned(gx * gx + gy * gy);
      word.magnitude = PIX_W'(floor_root(energy));
      word.row       = ROW_W'(r - 1);
      word.col       = COL_OUT_W'(c - 1);
      word.done      = (r == h - 1) && (c == w - 1);
      pending_edges.push_back(word);
    end
    prev2 = prev1;
    prev1 = now;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  // valid stays high after acceptance; the next call lowers or reuses it in the same step
  task automatic send_pixel(input logic [PIX_W-1:0] value);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel    <= value;
    do @(posedge clk); while (in_stall);
    predict_pixel(value);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_edges.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] reg_index,
                                input int unsigned value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= reg_index;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_index == REG_FRAME_WIDTH) width_reg = 32'(value[FW_W-1:0]);
    else height_reg = 32'(value[FH_W-1:0]);
  endtask

  task automatic send_noise(input int unsigned count);
    repeat (count) send_pixel(PIX_W'($urandom_range(255)));
  endtask

  function automatic logic [PIX_W-1:0] pick_pixel(input texture_e texture, input int base);
    int v;
    case (texture)
      TEX_NOISE:  v = $urandom_range(255);
      TEX_BINARY: v = $urandom_range(1) ? 255 : 0;
      default: begin
        v = base + int'($urandom_range(16)) - 8;
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
    endcase
    return PIX_W'(v);
  endfunction

  function automatic int unsigned pick_width();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom_range(2);
    if (roll < 25) return $urandom_range(64, 13);
    return $urandom_range(12, 3);
  endfunction

  function automatic int unsigned pick_height();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return $urandom_range(2);
    if (roll < 20) return $urandom_range(24, 11);
    return $urandom_range(10, 3);
  endfunction

  // three rows at the widest random width write every line entry that random frames read
  task automatic test_full_lines();
    write_register(REG_FRAME_WIDTH, 64);
    write_register(REG_FRAME_HEIGHT, 3);
    send_noise(64 * 3);
  endtask

  task automatic test_pixel_extremes();
    int r, c;
    write_register(REG_FRAME_WIDTH, 4);
    write_register(REG_FRAME_HEIGHT, 4);
    for (r = 0; r < 4; r++) begin
      for (c = 0; c < 4; c++) send_pixel((c >= 2) ? 8'hFF : 8'h00);
    end
    write_register(REG_FRAME_WIDTH, 3);
    write_register(REG_FRAME_HEIGHT, 3);
    repeat (9) send_pixel(8'hFF);
  endtask

  task automatic test_undersized_frame();
    write_register(REG_FRAME_WIDTH, 1);
    write_register(REG_FRAME_HEIGHT, 0);
    send_noise(9);
  endtask

  // oversize width, then shrink it past the column count, then shrink the height past the row
  task automatic test_midframe_writes();
    write_register(REG_FRAME_WIDTH, 2047);
    write_register(REG_FRAME_HEIGHT, 65535);
    send_noise(70);
    write_register(REG_FRAME_WIDTH, 5);
    send_noise(15);
    write_register(REG_FRAME_HEIGHT, 2);
    send_noise(15);
  endtask

  task automatic test_random_frames(input int unsigned item_goal);
    int unsigned sent, span, k;
    texture_e    texture;
    int          base;
    sent = 0;
    while (sent < item_goal) begin
      if ($urandom_range(3) != 0) write_register(REG_FRAME_WIDTH, pick_width());
      if ($urandom_range(3) != 0) write_register(REG_FRAME_HEIGHT, pick_height());
      span = active_width() * active_height();
      // cut a frame short now and then so the next one starts mid-frame
      if ($urandom_range(7) == 0) span = $urandom_range(span - 1, 1);
      if (span > item_goal - sent) span = item_goal - sent;
      texture = texture_e'($urandom_range(2));
      base    = $urandom_range(255);
      for (k = 0; k < span; k++) send_pixel(pick_pixel(texture, base));
      sent += span;
    end
  endtask

  task automatic compare_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    edge_word_t want;
    if (out_valid === 1'b1 && !out_stall) begin
      if (pending_edges.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected word, expected none, actual mag %0d row %0d col %0d",
                 $time, magnitude, out_row, out_col);
      end else begin
        want = pending_edges.pop_front();
        compare_field("magnitude", 16'(want.magnitude), 16'(magnitude));
        compare_field("out_row", want.row, out_row);
        compare_field("out_col", 16'(want.col), 16'(out_col));
        compare_field("frame_done", 16'(want.done), 16'(frame_done));
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_full_lines();
    test_pixel_extremes();
    test_undersized_frame();
    test_midframe_writes();
    test_random_frames(330);

    sender_idle_pct = 66;
    stall_pct       = 38;
    test_random_frames(330);

    sender_idle_pct = 0;
    stall_pct       = 0;
    test_random_frames(310);

    wait_idle();
    if (mismatch_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // roughly ten times the slowest expected run
  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
src/sem_pkg.sv
src/sem_ctrl.sv
src/sem_datapath.sv
src/sobel_edge_magnitude.sv
tb/testbench.sv
